// File: design/mdmr_pkg.sv
// shared types, codes and helpers of the meter data message receiver
`default_nettype none

package mdmr_pkg;

    localparam logic [6:0] CH_STX   = 7'h02;
    localparam logic [6:0] CH_ETX   = 7'h03;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_EXCL  = 7'h21;
    localparam logic [6:0] CH_OPEN  = 7'h28;
    localparam logic [6:0] CH_CLOSE = 7'h29;
    localparam logic [6:0] CH_STAR  = 7'h2A;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;

    localparam logic [1:0] CFG_ENERGY_KEY     = 2'd0;
    localparam logic [1:0] CFG_ENERGY_KEY_LEN = 2'd1;
    localparam logic [1:0] CFG_VOLUME_KEY     = 2'd2;
    localparam logic [1:0] CFG_VOLUME_KEY_LEN = 2'd3;

    localparam logic [63:0] ENERGY_KEY_RESET     = 64'h0000_0000_0038_2E36;
    localparam logic [3:0]  ENERGY_KEY_LEN_RESET = 4'd3;
    localparam logic [63:0] VOLUME_KEY_RESET     = 64'h0000_0000_3632_2E36;
    localparam logic [3:0]  VOLUME_KEY_LEN_RESET = 4'd4;
    localparam logic [31:0] ENERGY_RESET         = 32'hDEAD_CAFE;
    localparam logic [31:0] VOLUME_RESET         = 32'hAFFE_DEAD;

    localparam int KEY_CMP_CHARS = 8;
    localparam logic [2:0] END_SEQ_LEN = 3'd4;

    typedef enum logic [2:0] {
        ST_RECEIVING = 3'd0,
        ST_BCC_OK    = 3'd1,
        ST_BCC_BAD   = 3'd2,
        ST_NO_STX    = 3'd3,
        ST_PARITY    = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MSG_IDLE     = 2'd0,
        MSG_WAIT_STX = 2'd1,
        MSG_BODY     = 2'd2
    } t_msg_phase;

    typedef enum logic [1:0] {
        REC_KEY    = 2'd0,
        REC_ENERGY = 2'd1,
        REC_VOLUME = 2'd2,
        REC_SKIP   = 2'd3
    } t_rec_phase;

    typedef enum logic [1:0] {
        SEP_NONE       = 2'd0,
        SEP_STAR       = 2'd1,
        SEP_DOT_OPEN   = 2'd2,
        SEP_DOT_CLOSED = 2'd3
    } t_sep;

    typedef struct packed {
        logic       clear;
        logic       char_valid;
        logic [6:0] char_code;
    } t_parse_ctl;

    // elaboration-time power of ten
    function automatic logic [31:0] pow10(input int n);
        logic [31:0] v;
        v = 32'd1;
        for (int k = 0; k < n; k++) begin
            v = 32'(v * 32'd10);
        end
        return v;
    endfunction

    function automatic logic [6:0] end_char(input logic [1:0] idx);
        logic [6:0] c;
        case (idx)
            2'd0:    c = CH_EXCL;
            2'd1:    c = CH_CR;
            2'd2:    c = CH_LF;
            default: c = CH_ETX;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/mdmr_frame.sv
// message framing: stx check, bcc, end sequence tracking and status
`default_nettype none

module mdmr_frame (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_req_type,
    input  wire logic [6:0]            i_rx_byte,
    input  wire logic                  i_parity_error,
    output mdmr_pkg::t_status          o_status,
    output logic [6:0]                 o_bcc_next,
    output mdmr_pkg::t_parse_ctl       o_parse
);
    import mdmr_pkg::*;

    t_msg_phase r_phase, n_phase;
    logic [2:0] r_end_cnt, n_end_cnt;
    logic [6:0] r_bcc, n_bcc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= MSG_IDLE;
            r_end_cnt <= '0;
            r_bcc     <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_end_cnt <= n_end_cnt;
            r_bcc     <= n_bcc;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_end_cnt = r_end_cnt;
        n_bcc     = r_bcc;
        o_status  = ST_RECEIVING;
        o_parse   = '{clear: 1'b0, char_valid: 1'b0, char_code: i_rx_byte};
        if (!i_req_type) begin
            n_phase       = MSG_WAIT_STX;
            n_end_cnt     = '0;
            n_bcc         = '0;
            o_parse.clear = 1'b1;
        end else begin
            unique case (r_phase)
                MSG_IDLE: begin
                    o_status = ST_IGNORED;
                end
                MSG_WAIT_STX: begin
                    if (i_parity_error) begin
                        o_status = ST_PARITY;
                        n_phase  = MSG_IDLE;
                    end else if (i_rx_byte != CH_STX) begin
                        o_status = ST_NO_STX;
                        n_phase  = MSG_IDLE;
                    end else begin
                        o_parse.clear = 1'b1;
                        n_phase       = MSG_BODY;
                    end
                end
                MSG_BODY: begin
                    if (i_parity_error) begin
                        o_status = ST_PARITY;
                        n_phase  = MSG_IDLE;
                    end else if (r_end_cnt >= END_SEQ_LEN) begin
                        o_status = (i_rx_byte == r_bcc) ? ST_BCC_OK : ST_BCC_BAD;
                        n_phase  = MSG_IDLE;
                    end else begin
                        n_bcc = r_bcc ^ i_rx_byte;
                        if (i_rx_byte == end_char(r_end_cnt[1:0])) begin
                            n_end_cnt = r_end_cnt + 3'd1;
                        end else if (r_end_cnt != '0) begin
                            n_end_cnt = '0;
                        end else begin
                            o_parse.char_valid = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = MSG_IDLE;
                end
            endcase
        end
    end

    assign o_bcc_next = n_bcc;

endmodule

`default_nettype wire

// File: design/mdmr_parser.sv
// record parser: key capture, key match, fixed point value build and value registers
`default_nettype none

module mdmr_parser #(
    parameter int KEY_MAX_CHARS   = 8,
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire mdmr_pkg::t_parse_ctl  i_parse,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data,
    output logic [31:0]                o_energy_next,
    output logic [31:0]                o_volume_next
);
    import mdmr_pkg::*;

    localparam int KLW = $clog2(KEY_MAX_CHARS + 2);
    localparam int KIW = $clog2(KEY_MAX_CHARS);
    localparam int FW  = $clog2(10 ** FRACTION_DIGITS);
    localparam int CW  = $clog2(FRACTION_DIGITS + 1);
    localparam logic [31:0] SCALE = pow10(FRACTION_DIGITS);

    logic [63:0] r_energy_key, r_volume_key;
    logic [3:0]  r_energy_len, r_volume_len;

    t_rec_phase  r_rec, n_rec;
    t_sep        r_sep, n_sep;
    logic [6:0]  r_key_chars [KEY_MAX_CHARS];
    logic [6:0]  n_key_chars [KEY_MAX_CHARS];
    logic [KLW-1:0] r_key_len, n_key_len;
    logic [31:0] r_digit_s, n_digit_s;
    logic [31:0] r_int_s, n_int_s;
    logic [FW-1:0] r_frac_s, n_frac_s;
    logic [CW-1:0] r_frac_cnt, n_frac_cnt;
    logic [31:0] r_energy, n_energy;
    logic [31:0] r_volume, n_volume;

    logic [FW-1:0] w_frac_weight [2 ** CW];
    logic [KEY_CMP_CHARS-1:0] w_e_eq, w_v_eq;
    logic w_e_match, w_v_match;
    logic [6:0] w_c;
    logic [3:0] w_d;
    logic w_is_digit;
    logic [31:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_key <= ENERGY_KEY_RESET;
            r_energy_len <= ENERGY_KEY_LEN_RESET;
            r_volume_key <= VOLUME_KEY_RESET;
            r_volume_len <= VOLUME_KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENERGY_KEY:     r_energy_key <= i_cfg_data;
                CFG_ENERGY_KEY_LEN: r_energy_len <= i_cfg_data[3:0];
                CFG_VOLUME_KEY:     r_volume_key <= i_cfg_data;
                CFG_VOLUME_KEY_LEN: r_volume_len <= i_cfg_data[3:0];
                default:            r_energy_len <= r_energy_len;
            endcase
        end
    end

    generate
        for (genvar g = 0; g < 2 ** CW; g++) begin : g_weight
            if (g < FRACTION_DIGITS) begin : g_used
                assign w_frac_weight[g] = FW'(pow10(FRACTION_DIGITS - 1 - g));
            end else begin : g_unused
                assign w_frac_weight[g] = '0;
            end
        end
        for (genvar i = 0; i < KEY_CMP_CHARS; i++) begin : g_cmp
            if (i < KEY_MAX_CHARS) begin : g_cmp_used
                assign w_e_eq[i] = (r_energy_key[8*i +: 8] == {1'b0, r_key_chars[i]});
                assign w_v_eq[i] = (r_volume_key[8*i +: 8] == {1'b0, r_key_chars[i]});
            end else begin : g_cmp_unused
                assign w_e_eq[i] = 1'b0;
                assign w_v_eq[i] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        w_e_match = (r_energy_len != 4'd0) && (32'(r_energy_len) <= 32'(KEY_CMP_CHARS))
                 && (32'(r_energy_len) <= 32'(KEY_MAX_CHARS))
                 && (32'(r_key_len) == 32'(r_energy_len));
        w_v_match = (r_volume_len != 4'd0) && (32'(r_volume_len) <= 32'(KEY_CMP_CHARS))
                 && (32'(r_volume_len) <= 32'(KEY_MAX_CHARS))
                 && (32'(r_key_len) == 32'(r_volume_len));
        for (int i = 0; i < KEY_CMP_CHARS; i++) begin
            if (32'(i) < 32'(r_energy_len) && !w_e_eq[i]) begin
                w_e_match = 1'b0;
            end
            if (32'(i) < 32'(r_volume_len) && !w_v_eq[i]) begin
                w_v_match = 1'b0;
            end
        end
    end

    assign w_c        = i_parse.char_code;
    assign w_d        = w_c[3:0];
    assign w_is_digit = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_value    = ((r_sep == SEP_NONE) ? r_digit_s : r_int_s)
                      + (((r_sep == SEP_DOT_OPEN) || (r_sep == SEP_DOT_CLOSED))
                         ? 32'(r_frac_s) : 32'd0);

    always_comb begin
        n_rec       = r_rec;
        n_sep       = r_sep;
        n_key_chars = r_key_chars;
        n_key_len   = r_key_len;
        n_digit_s   = r_digit_s;
        n_int_s     = r_int_s;
        n_frac_s    = r_frac_s;
        n_frac_cnt  = r_frac_cnt;
        n_energy    = r_energy;
        n_volume    = r_volume;
        if (i_parse.clear) begin
            n_rec     = REC_KEY;
            n_key_len = '0;
        end else if (i_parse.char_valid) begin
            case (r_rec)
                REC_KEY: begin
                    if (r_key_len == '0 && (w_c == CH_CR || w_c == CH_LF)) begin
                        n_rec = r_rec;
                    end else if (w_c == CH_OPEN) begin
                        if (w_e_match) begin
                            n_rec = REC_ENERGY;
                        end else if (w_v_match) begin
                            n_rec = REC_VOLUME;
                        end else begin
                            n_rec = REC_SKIP;
                        end
                        n_digit_s  = '0;
                        n_int_s    = '0;
                        n_frac_s   = '0;
                        n_frac_cnt = '0;
                        n_sep      = SEP_NONE;
                    end else if (32'(r_key_len) < 32'(KEY_MAX_CHARS)) begin
                        n_key_chars[r_key_len[KIW-1:0]] = w_c;
                        n_key_len = r_key_len + KLW'(1);
                    end else begin
                        n_key_len = KLW'(KEY_MAX_CHARS + 1);
                    end
                end
                REC_SKIP: begin
                    if (w_c == CH_CLOSE) begin
                        n_rec     = REC_KEY;
                        n_key_len = '0;
                    end
                end
                default: begin
                    if (w_c == CH_CLOSE) begin
                        if (r_rec == REC_ENERGY) begin
                            n_energy = w_value;
                        end else begin
                            n_volume = w_value;
                        end
                        n_rec     = REC_KEY;
                        n_key_len = '0;
                    end else if (r_sep == SEP_DOT_OPEN) begin
                        if (w_is_digit) begin
                            if (32'(r_frac_cnt) < 32'(FRACTION_DIGITS)) begin
                                n_frac_s   = r_frac_s + FW'(FW'(w_d) * w_frac_weight[r_frac_cnt]);
                                n_frac_cnt = r_frac_cnt + CW'(1);
                            end
                        end else begin
                            n_sep = SEP_DOT_CLOSED;
                        end
                    end else if (r_sep == SEP_DOT_CLOSED) begin
                        n_sep = r_sep;
                    end else if (w_c == CH_DOT) begin
                        n_int_s = r_digit_s;
                        n_sep   = SEP_DOT_OPEN;
                    end else if (w_c == CH_STAR && r_sep == SEP_NONE) begin
                        n_int_s   = r_digit_s;
                        n_sep     = SEP_STAR;
                        n_digit_s = '0;
                    end else if (w_is_digit) begin
                        // digit run kept already scaled, wraps mod 2^32
                        n_digit_s = 32'(r_digit_s * 32'd10) + 32'(32'(w_d) * SCALE);
                    end else begin
                        n_digit_s = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec      <= REC_KEY;
            r_sep      <= SEP_NONE;
            r_key_len  <= '0;
            r_digit_s  <= '0;
            r_int_s    <= '0;
            r_frac_s   <= '0;
            r_frac_cnt <= '0;
            r_energy   <= ENERGY_RESET;
            r_volume   <= VOLUME_RESET;
        end else if (i_en) begin
            r_rec      <= n_rec;
            r_sep      <= n_sep;
            r_key_len  <= n_key_len;
            r_digit_s  <= n_digit_s;
            r_int_s    <= n_int_s;
            r_frac_s   <= n_frac_s;
            r_frac_cnt <= n_frac_cnt;
            r_energy   <= n_energy;
            r_volume   <= n_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key_chars <= n_key_chars;
        end
    end

    assign o_energy_next = n_energy;
    assign o_volume_next = n_volume;

endmodule

`default_nettype wire

// File: design/meter_data_message_receiver_unit.sv
// Meter data message receiver: takes an IEC 62056-21 data message one 7-bit character per
// transaction, checks STX, the end sequence and the BCC, and extracts the energy and volume
// values as fixed point with FRACTION_DIGITS decimals. One transaction is accepted every
// cycle while the output is not stalled; each transaction passes the input register, then
// the result register. Every input transaction gives exactly one result transaction.
// Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write them only while the block is idle, and the block does not enforce it.
`default_nettype none

module meter_data_message_receiver_unit #(
    parameter int KEY_MAX_CHARS   = 8,
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // rx_byte[6:0], zero pad
    input  wire logic [1:0]   s_axis_tuser,   // req_type, parity_error
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // energy_value, volume_value, computed_bcc, pad
    output logic [2:0]        m_axis_tuser,   // status
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import mdmr_pkg::*;

    logic        r_in_valid;
    logic        r_req_type;
    logic [6:0]  r_rx_byte;
    logic        r_parity_error;
    logic        r_out_valid;
    t_status     r_status;
    logic [31:0] r_energy;
    logic [31:0] r_volume;
    logic [6:0]  r_bcc;

    logic        w_adv;
    t_status     w_status;
    logic [6:0]  w_bcc_next;
    t_parse_ctl  w_parse;
    logic [31:0] w_energy_next;
    logic [31:0] w_volume_next;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req_type     <= s_axis_tuser[0];
            r_parity_error <= s_axis_tuser[1];
            r_rx_byte      <= s_axis_tdata[6:0];
        end
    end

    mdmr_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_req_type     (r_req_type),
        .i_rx_byte      (r_rx_byte),
        .i_parity_error (r_parity_error),
        .o_status       (w_status),
        .o_bcc_next     (w_bcc_next),
        .o_parse        (w_parse)
    );

    mdmr_parser #(
        .KEY_MAX_CHARS   (KEY_MAX_CHARS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_parse       (w_parse),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_energy_next (w_energy_next),
        .o_volume_next (w_volume_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= w_status;
            r_energy <= w_energy_next;
            r_volume <= w_volume_next;
            r_bcc    <= w_bcc_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_bcc, r_volume, r_energy};
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire
